/* sv/qwdtm_pkg.sv */
// ---------------------------------------------------------------------------
// qwdtm_pkg
// Shared widths, operation and register codes, reset values, arithmetic
// constants and default geometry of the quad-warp depth touch map.
// ---------------------------------------------------------------------------
package qwdtm_pkg;

  // Field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned CORNER_W   = 20;
  localparam int unsigned RANGE_W    = 10;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Item operations
  localparam logic [OP_W-1:0] OP_WRITE_BG   = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_LIVE = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_TL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_TR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_BR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_BL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 3'd5;

  // Register reset values
  localparam logic [CORNER_W-1:0] RST_CORNER_TL  = 20'd0;
  localparam logic [CORNER_W-1:0] RST_CORNER_TR  = 20'd640;
  localparam logic [CORNER_W-1:0] RST_CORNER_BR  = 20'd492160;
  localparam logic [CORNER_W-1:0] RST_CORNER_BL  = 20'd491520;
  localparam logic [RANGE_W-1:0]  RST_RANGE_LOW  = 10'd30;
  localparam logic [RANGE_W-1:0]  RST_RANGE_HIGH = 10'd150;

  // Arithmetic constants
  localparam logic [FRAC_W:0]     ONE_Q16   = 17'h10000;
  localparam logic [VALUE_W-1:0]  MAX_VALUE = 8'd255;

  // Default geometry
  localparam int unsigned DEF_DEPTH_WIDTH   = 640;
  localparam int unsigned DEF_DEPTH_HEIGHT  = 480;
  localparam int unsigned DEF_SCREEN_WIDTH  = 640;
  localparam int unsigned DEF_SCREEN_HEIGHT = 480;

endpackage

/* sv/quad_warp_depth_touch_map_top.sv */
// ---------------------------------------------------------------------------
// quad_warp_depth_touch_map_top
// Throughput: one item per cycle; the pipeline stalls only when every stage
// is full and the output is held.
// Reset: clears the stage valid bits and loads the register defaults; the two
// frame memories are not cleared and hold garbage until written.
// Pipeline: fraction, weights, corner products, blend sum, address, memory
// read, delta, seven divider steps, output register with the last step.
// ---------------------------------------------------------------------------
module quad_warp_depth_touch_map_top #(
  parameter int unsigned DEPTH_WIDTH   = qwdtm_pkg::DEF_DEPTH_WIDTH,
  parameter int unsigned DEPTH_HEIGHT  = qwdtm_pkg::DEF_DEPTH_HEIGHT,
  parameter int unsigned SCREEN_WIDTH  = qwdtm_pkg::DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = qwdtm_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input item channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [qwdtm_pkg::OP_W-1:0]          operation_i,
  input  logic [qwdtm_pkg::COORD_W-1:0]       pixel_col_i,
  input  logic [qwdtm_pkg::COORD_W-1:0]       pixel_row_i,
  input  logic [qwdtm_pkg::DEPTH_W-1:0]       depth_value_i,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [qwdtm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [qwdtm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // result item channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [qwdtm_pkg::COORD_W-1:0]       out_col_o,
  output logic [qwdtm_pkg::COORD_W-1:0]       out_row_o,
  output logic [qwdtm_pkg::VALUE_W-1:0]       out_value_o
);

  localparam int unsigned MEM_DEPTH   = DEPTH_WIDTH * DEPTH_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(MEM_DEPTH);
  localparam int unsigned ADDR_FULL_W = 2 * qwdtm_pkg::COORD_W;
  localparam int unsigned COORD_W     = qwdtm_pkg::COORD_W;
  localparam int unsigned FRAC_W      = qwdtm_pkg::FRAC_W;
  localparam int unsigned DEPTH_W     = qwdtm_pkg::DEPTH_W;
  localparam int unsigned VALUE_W     = qwdtm_pkg::VALUE_W;
  localparam int unsigned RANGE_W     = qwdtm_pkg::RANGE_W;
  localparam int unsigned NUM_W       = RANGE_W + VALUE_W;

  // Reciprocal of the screen size: exact floor(col * 2^16 / size) for all
  // col < 2^10 when scaled by 2^36.
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned RECIP_W     = 33;
  localparam int unsigned FPROD_W     = COORD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_X = RECIP_W'(((64'd1 << RECIP_SHIFT) +
                                           64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));
  localparam logic [RECIP_W-1:0] RECIP_Y = RECIP_W'(((64'd1 << RECIP_SHIFT) +
                                           64'(SCREEN_HEIGHT) - 64'd1) / 64'(SCREEN_HEIGHT));

  // Q1.32 weights and weighted corner products
  localparam int unsigned WGT_W  = 2 * FRAC_W + 1;
  localparam int unsigned PROD_W = WGT_W + COORD_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned SUM_LSB = 2 * FRAC_W;

  // Stage numbers
  localparam int unsigned STG_FRAC  = 1;
  localparam int unsigned STG_WGT   = 2;
  localparam int unsigned STG_PROD  = 3;
  localparam int unsigned STG_SUM   = 4;
  localparam int unsigned STG_ADDR  = 5;
  localparam int unsigned STG_READ  = 6;
  localparam int unsigned STG_DELTA = 7;
  localparam int unsigned STG_OUT   = STG_DELTA + VALUE_W;

  typedef struct packed {
    logic [qwdtm_pkg::OP_W-1:0] op;
    logic [COORD_W-1:0]         col;
    logic [COORD_W-1:0]         row;
    logic [DEPTH_W-1:0]         val;
    logic                       scr_ok;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pos_t;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [qwdtm_pkg::CORNER_W-1:0] corner_tl_q, corner_tr_q, corner_br_q, corner_bl_q;
  logic [RANGE_W-1:0]             range_low_q, range_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_tl_q  <= qwdtm_pkg::RST_CORNER_TL;
      corner_tr_q  <= qwdtm_pkg::RST_CORNER_TR;
      corner_br_q  <= qwdtm_pkg::RST_CORNER_BR;
      corner_bl_q  <= qwdtm_pkg::RST_CORNER_BL;
      range_low_q  <= qwdtm_pkg::RST_RANGE_LOW;
      range_high_q <= qwdtm_pkg::RST_RANGE_HIGH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qwdtm_pkg::REG_CORNER_TL:  corner_tl_q  <= cfg_data_i;
        qwdtm_pkg::REG_CORNER_TR:  corner_tr_q  <= cfg_data_i;
        qwdtm_pkg::REG_CORNER_BR:  corner_br_q  <= cfg_data_i;
        qwdtm_pkg::REG_CORNER_BL:  corner_bl_q  <= cfg_data_i;
        qwdtm_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_data_i[RANGE_W-1:0];
        qwdtm_pkg::REG_RANGE_HIGH: range_high_q <= cfg_data_i[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Corner coordinates in weight order: top-left, top-right, bottom-right, bottom-left
  logic [COORD_W-1:0] corner_x [4];
  logic [COORD_W-1:0] corner_y [4];

  assign corner_x[0] = corner_tl_q[COORD_W-1:0];
  assign corner_x[1] = corner_tr_q[COORD_W-1:0];
  assign corner_x[2] = corner_br_q[COORD_W-1:0];
  assign corner_x[3] = corner_bl_q[COORD_W-1:0];
  assign corner_y[0] = corner_tl_q[2*COORD_W-1:COORD_W];
  assign corner_y[1] = corner_tr_q[2*COORD_W-1:COORD_W];
  assign corner_y[2] = corner_br_q[2*COORD_W-1:COORD_W];
  assign corner_y[3] = corner_bl_q[2*COORD_W-1:COORD_W];

  // -------------------------------------------------------------------------
  // Stage flow control: a stage loads when it is empty or its item moves on
  // -------------------------------------------------------------------------
  logic [STG_OUT:1] vld_q;
  logic [STG_OUT:1] vld_in;
  logic [STG_OUT:1] stg_rdy;

  item_t              itm_q [STG_FRAC:STG_ADDR];
  logic [ADDR_W-1:0]  addr_q;
  logic               ok_q;

  always_comb begin
    stg_rdy[STG_OUT] = !vld_q[STG_OUT] || !out_stall_i;
    for (int k = STG_OUT - 1; k >= 1; k--) begin
      stg_rdy[k] = !vld_q[k] || stg_rdy[k+1];
    end
  end

  // Writes and dropped computes leave the pipe at the memory stage
  always_comb begin
    vld_in[1] = in_valid_i;
    for (int k = 2; k <= STG_OUT; k++) begin
      vld_in[k] = vld_q[k-1];
    end
    vld_in[STG_READ] = vld_q[STG_ADDR] && ok_q &&
                       (itm_q[STG_ADDR].op == qwdtm_pkg::OP_COMPUTE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= STG_OUT; k++) begin
        if (stg_rdy[k]) vld_q[k] <= vld_in[k];
      end
    end
  end

  assign in_stall_o = !stg_rdy[1];

  // -------------------------------------------------------------------------
  // Stage 1: screen position to Q0.16 fractions
  // -------------------------------------------------------------------------
  logic [FPROD_W-1:0] frac_x_full, frac_y_full;
  logic [FRAC_W-1:0]  frac_a_q, frac_b_q;

  assign frac_x_full = FPROD_W'(pixel_col_i) * FPROD_W'(RECIP_X);
  assign frac_y_full = FPROD_W'(pixel_row_i) * FPROD_W'(RECIP_Y);

  always_ff @(posedge clk_i) begin
    if (stg_rdy[STG_FRAC]) begin
      frac_a_q <= frac_x_full[RECIP_SHIFT-1:RECIP_SHIFT-FRAC_W];
      frac_b_q <= frac_y_full[RECIP_SHIFT-1:RECIP_SHIFT-FRAC_W];
      itm_q[STG_FRAC].op     <= operation_i;
      itm_q[STG_FRAC].col    <= pixel_col_i;
      itm_q[STG_FRAC].row    <= pixel_row_i;
      itm_q[STG_FRAC].val    <= depth_value_i;
      itm_q[STG_FRAC].scr_ok <= (pixel_col_i < COORD_W'(SCREEN_WIDTH)) &&
                                (pixel_row_i < COORD_W'(SCREEN_HEIGHT));
    end
  end

  // Carry the item alongside the mapping stages
  always_ff @(posedge clk_i) begin
    for (int k = STG_WGT; k <= STG_ADDR; k++) begin
      if (stg_rdy[k]) itm_q[k] <= itm_q[k-1];
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: bilinear weights, exact Q1.32
  // -------------------------------------------------------------------------
  logic [FRAC_W:0]    frac_na, frac_nb;
  logic [WGT_W-1:0]   wgt_q [4];

  assign frac_na = qwdtm_pkg::ONE_Q16 - (FRAC_W+1)'(frac_a_q);
  assign frac_nb = qwdtm_pkg::ONE_Q16 - (FRAC_W+1)'(frac_b_q);

  always_ff @(posedge clk_i) begin
    if (stg_rdy[STG_WGT]) begin
      wgt_q[0] <= WGT_W'((WGT_W+1)'(frac_na) * (WGT_W+1)'(frac_nb));
      wgt_q[1] <= WGT_W'((WGT_W+1)'(frac_a_q) * (WGT_W+1)'(frac_nb));
      wgt_q[2] <= WGT_W'((WGT_W+1)'(frac_a_q) * (WGT_W+1)'(frac_b_q));
      wgt_q[3] <= WGT_W'((WGT_W+1)'(frac_na) * (WGT_W+1)'(frac_b_q));
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: weight each corner coordinate
  // -------------------------------------------------------------------------
  logic [PROD_W-1:0] prod_x_q [4];
  logic [PROD_W-1:0] prod_y_q [4];

  always_ff @(posedge clk_i) begin
    if (stg_rdy[STG_PROD]) begin
      for (int c = 0; c < 4; c++) begin
        prod_x_q[c] <= PROD_W'(wgt_q[c]) * PROD_W'(corner_x[c]);
        prod_y_q[c] <= PROD_W'(wgt_q[c]) * PROD_W'(corner_y[c]);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stage 4: blend sum, truncate to integer depth coordinates
  // -------------------------------------------------------------------------
  logic [SUM_W-1:0]   sum_x, sum_y;
  logic [COORD_W-1:0] depth_x_q, depth_y_q;

  assign sum_x = SUM_W'(prod_x_q[0]) + SUM_W'(prod_x_q[1]) +
                 SUM_W'(prod_x_q[2]) + SUM_W'(prod_x_q[3]);
  assign sum_y = SUM_W'(prod_y_q[0]) + SUM_W'(prod_y_q[1]) +
                 SUM_W'(prod_y_q[2]) + SUM_W'(prod_y_q[3]);

  always_ff @(posedge clk_i) begin
    if (stg_rdy[STG_SUM]) begin
      depth_x_q <= sum_x[SUM_LSB+COORD_W-1:SUM_LSB];
      depth_y_q <= sum_y[SUM_LSB+COORD_W-1:SUM_LSB];
    end
  end

  // -------------------------------------------------------------------------
  // Stage 5: frame address for writes and computes alike
  // -------------------------------------------------------------------------
  logic               sel_cmp;
  logic [COORD_W-1:0] sel_x, sel_y;
  logic               sel_ok;
  logic [ADDR_FULL_W-1:0] sel_addr;

  assign sel_cmp  = itm_q[STG_SUM].op == qwdtm_pkg::OP_COMPUTE;
  assign sel_x    = sel_cmp ? depth_x_q : itm_q[STG_SUM].col;
  assign sel_y    = sel_cmp ? depth_y_q : itm_q[STG_SUM].row;
  assign sel_ok   = (sel_x < COORD_W'(DEPTH_WIDTH)) && (sel_y < COORD_W'(DEPTH_HEIGHT)) &&
                    (!sel_cmp || itm_q[STG_SUM].scr_ok);
  assign sel_addr = ADDR_FULL_W'(sel_x) + ADDR_FULL_W'(sel_y) * ADDR_FULL_W'(DEPTH_WIDTH);

  always_ff @(posedge clk_i) begin
    if (stg_rdy[STG_ADDR]) begin
      addr_q <= sel_addr[ADDR_W-1:0];
      ok_q   <= sel_ok;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 6: frame memories. Reads and writes issue from the same stage in
  // item order, so a read always sees every earlier write.
  // -------------------------------------------------------------------------
  logic [DEPTH_W-1:0] bg_mem_q [MEM_DEPTH];
  logic [DEPTH_W-1:0] lv_mem_q [MEM_DEPTH];
  logic [DEPTH_W-1:0] bg_rd_q, lv_rd_q;
  logic               mem_go;
  logic               mem_rd;
  logic               bg_wr, lv_wr;

  assign mem_go = stg_rdy[STG_READ] && vld_q[STG_ADDR] && ok_q;
  assign mem_rd = mem_go && (itm_q[STG_ADDR].op == qwdtm_pkg::OP_COMPUTE);
  assign bg_wr  = mem_go && (itm_q[STG_ADDR].op == qwdtm_pkg::OP_WRITE_BG);
  assign lv_wr  = mem_go && (itm_q[STG_ADDR].op == qwdtm_pkg::OP_WRITE_LIVE);

  always_ff @(posedge clk_i) begin
    if (bg_wr) bg_mem_q[addr_q] <= itm_q[STG_ADDR].val;
    if (mem_rd) bg_rd_q <= bg_mem_q[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (lv_wr) lv_mem_q[addr_q] <= itm_q[STG_ADDR].val;
    if (mem_rd) lv_rd_q <= lv_mem_q[addr_q];
  end

  // Screen position rides along to the output
  pos_t pos_q [STG_READ:STG_OUT];

  always_ff @(posedge clk_i) begin
    if (stg_rdy[STG_READ]) begin
      pos_q[STG_READ].col <= itm_q[STG_ADDR].col;
      pos_q[STG_READ].row <= itm_q[STG_ADDR].row;
    end
    for (int k = STG_READ + 1; k <= STG_OUT; k++) begin
      if (stg_rdy[k]) pos_q[k] <= pos_q[k-1];
    end
  end

  // -------------------------------------------------------------------------
  // Stage 7: depth difference, range test, scaled numerator
  // -------------------------------------------------------------------------
  logic [DEPTH_W:0]   delta;
  logic               in_range;
  logic [RANGE_W-1:0] delta_off;
  logic [RANGE_W-1:0] div_den;

  logic [NUM_W-1:0]   rem_q  [STG_DELTA:STG_OUT-1];
  logic [VALUE_W-1:0] quo_q  [STG_DELTA:STG_OUT-1];
  logic               pass_q [STG_DELTA:STG_OUT-1];

  assign delta     = (DEPTH_W+1)'(bg_rd_q) - (DEPTH_W+1)'(lv_rd_q);
  assign in_range  = (bg_rd_q != '0) && (lv_rd_q != '0) && !delta[DEPTH_W] &&
                     (delta[DEPTH_W-1:0] >= DEPTH_W'(range_low_q)) &&
                     (delta[DEPTH_W-1:0] <= DEPTH_W'(range_high_q));
  assign delta_off = RANGE_W'(delta[DEPTH_W-1:0] - DEPTH_W'(range_low_q));
  // User must change registers only while idle (not enforced); all steps use div_den
  assign div_den   = range_high_q - range_low_q;

  always_ff @(posedge clk_i) begin
    if (stg_rdy[STG_DELTA]) begin
      rem_q[STG_DELTA]  <= NUM_W'(delta_off) * NUM_W'(qwdtm_pkg::MAX_VALUE);
      quo_q[STG_DELTA]  <= '0;
      pass_q[STG_DELTA] <= in_range && (range_high_q != range_low_q);
    end
  end

  // -------------------------------------------------------------------------
  // Stages 8..15: restoring divider, one quotient bit per stage, MSB first
  // -------------------------------------------------------------------------
  logic [NUM_W:0] trial [STG_DELTA+1:STG_OUT];

  always_comb begin
    for (int k = STG_DELTA + 1; k <= STG_OUT; k++) begin
      trial[k] = {1'b0, rem_q[k-1]} -
                 ((NUM_W+1)'(div_den) << (STG_DELTA + VALUE_W - k));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = STG_DELTA + 1; k < STG_OUT; k++) begin
      if (stg_rdy[k]) begin
        rem_q[k]  <= trial[k][NUM_W] ? rem_q[k-1] : trial[k][NUM_W-1:0];
        quo_q[k]  <= quo_q[k-1] |
                     (trial[k][NUM_W] ? '0 : VALUE_W'(1) << (STG_DELTA + VALUE_W - k));
        pass_q[k] <= pass_q[k-1];
      end
    end
  end

  // Output register: last quotient bit, then zero anything out of range
  logic [VALUE_W-1:0] out_value_q;

  always_ff @(posedge clk_i) begin
    if (stg_rdy[STG_OUT]) begin
      out_value_q <= pass_q[STG_OUT-1] ?
                     (quo_q[STG_OUT-1] | VALUE_W'(!trial[STG_OUT][NUM_W])) : '0;
    end
  end

  assign out_valid_o = vld_q[STG_OUT];
  assign out_col_o   = pos_q[STG_OUT].col;
  assign out_row_o   = pos_q[STG_OUT].row;
  assign out_value_o = out_value_q;

endmodule

/* sv/qwdtm_checker.sv */
// ---------------------------------------------------------------------------
// qwdtm_checker
// Port-level checks on the touch map: output hold under stall, result
// coordinates on screen, and input stall only behind a held output.
// ---------------------------------------------------------------------------
module qwdtm_checker #(
  parameter int unsigned SCREEN_WIDTH  = qwdtm_pkg::DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = qwdtm_pkg::DEF_SCREEN_HEIGHT
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [qwdtm_pkg::COORD_W-1:0]     out_col_o,
  input logic [qwdtm_pkg::COORD_W-1:0]     out_row_o,
  input logic [qwdtm_pkg::VALUE_W-1:0]     out_value_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_col_o) && $stable(out_row_o) && $stable(out_value_o))
    else $error("result changed while stalled");

  // Results only name screen pixels
  a_out_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_col_o < qwdtm_pkg::COORD_W'(SCREEN_WIDTH)) &&
                    (out_row_o < qwdtm_pkg::COORD_W'(SCREEN_HEIGHT)))
    else $error("result outside the screen");

  // Back-pressure only comes from a held output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

endmodule

bind quad_warp_depth_touch_map_top qwdtm_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_qwdtm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_col_o   (out_col_o),
  .out_row_o   (out_row_o),
  .out_value_o (out_value_o)
);
